// ===== design/sgls_pkg.sv =====
// ----------------------------------------------------------------------------
// sgls_pkg
// Types, register indexes and constants shared by the strain pipeline.
// ----------------------------------------------------------------------------
package sgls_pkg;

    localparam int N_TERM = 9;
    localparam int N_COMP = 6;

    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_DSCALE_X = 3'd1;
    localparam logic [2:0] CFG_DSCALE_Y = 3'd2;
    localparam logic [2:0] CFG_DSCALE_Z = 3'd3;
    localparam logic [2:0] CFG_CRECIP_X = 3'd4;
    localparam logic [2:0] CFG_CRECIP_Y = 3'd5;
    localparam logic [2:0] CFG_CRECIP_Z = 3'd6;

    localparam logic [1:0] MODE_PLANAR = 2'd2;
    localparam logic [1:0] MODE_FULL   = 2'd3;

    localparam logic [15:0] SCALE_ONE = 16'd256;

    // tensor component order: xx, yy, zz, xy, yz, xz
    localparam int OI [N_COMP] = '{0, 1, 2, 0, 1, 0};
    localparam int OJ [N_COMP] = '{0, 1, 2, 1, 2, 2};

    typedef logic signed [16:0] t_fterm;
    typedef logic signed [33:0] t_prod;

    typedef struct packed {
        logic signed [15:0] g_ux_dx;
        logic signed [15:0] g_ux_dy;
        logic signed [15:0] g_ux_dz;
        logic signed [15:0] g_uy_dx;
        logic signed [15:0] g_uy_dy;
        logic signed [15:0] g_uy_dz;
        logic signed [15:0] g_uz_dx;
        logic signed [15:0] g_uz_dy;
        logic signed [15:0] g_uz_dz;
    } t_sgls_in;

    typedef struct packed {
        logic signed [31:0] strain_xx;
        logic signed [31:0] strain_yy;
        logic signed [31:0] strain_zz;
        logic signed [31:0] strain_xy;
        logic signed [31:0] strain_yz;
        logic signed [31:0] strain_xz;
        logic               saturated;
    } t_sgls_out;

    typedef struct packed {
        logic             planar;
        logic [2:0][15:0] dscale;
        logic [2:0][15:0] crecip;
    } t_sgls_cfg;

    typedef struct packed {
        logic en;
        logic planar;
    } t_sgls_ctrl;

endpackage

// ===== design/sgls_scale.sv =====
// ----------------------------------------------------------------------------
// sgls_scale
// Scales each gradient term by its row and column factors, rounds and
// saturates to Q4.12, and forms F = I + G. Three register stages.
// ----------------------------------------------------------------------------
module sgls_scale import sgls_pkg::*; (
    input  logic       i_clk,
    input  t_sgls_ctrl i_ctrl,
    input  t_sgls_cfg  i_cfg,
    input  t_sgls_in   i_in,
    output t_fterm     o_f [N_TERM],
    output logic       o_clip
);

    logic signed [15:0] g [N_TERM];
    logic signed [31:0] r_gd [N_TERM];
    logic signed [47:0] r_p [N_TERM];
    t_fterm             n_f [N_TERM];
    logic               n_clip;
    t_fterm             r_f [N_TERM];
    logic               r_clip;

    always_comb begin
        g[0] = i_in.g_ux_dx;
        g[1] = i_in.g_ux_dy;
        g[2] = i_in.g_ux_dz;
        g[3] = i_in.g_uy_dx;
        g[4] = i_in.g_uy_dy;
        g[5] = i_in.g_uy_dz;
        g[6] = i_in.g_uz_dx;
        g[7] = i_in.g_uz_dy;
        g[8] = i_in.g_uz_dz;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_gd[r*3+c] <= g[r*3+c] * $signed({1'b0, i_cfg.dscale[r]});
                    r_p[r*3+c]  <= r_gd[r*3+c] * $signed({1'b0, i_cfg.crecip[c]});
                end
            end
        end
    end

    always_comb begin
        logic signed [47:0] rnd;
        logic signed [47:0] q;
        logic signed [15:0] t;
        logic               used;
        n_clip = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                rnd  = r_p[r*3+c] + 48'sd32768;
                q    = rnd >>> 16;
                used = !(i_ctrl.planar && (r == 2 || c == 2));
                if (q > 48'sd32767) begin
                    t = 16'sh7fff;
                    n_clip = n_clip | used;
                end else if (q < -48'sd32768) begin
                    t = 16'sh8000;
                    n_clip = n_clip | used;
                end else begin
                    t = q[15:0];
                end
                if (!used) begin
                    n_f[r*3+c] = 17'sd0;
                end else if (r == c) begin
                    n_f[r*3+c] = {t[15], t} + 17'sd4096;
                end else begin
                    n_f[r*3+c] = {t[15], t};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_f    <= n_f;
            r_clip <= n_clip;
        end
    end

    assign o_f    = r_f;
    assign o_clip = r_clip;

endmodule

// ===== design/sgls_strain.sv =====
// ----------------------------------------------------------------------------
// sgls_strain
// Forms the column dot products of F, removes identity on the diagonal,
// halves, rounds and saturates to Q15.16. Two register stages.
// ----------------------------------------------------------------------------
module sgls_strain import sgls_pkg::*; (
    input  logic       i_clk,
    input  t_sgls_ctrl i_ctrl,
    input  t_fterm     i_f [N_TERM],
    input  logic       i_clip,
    output t_sgls_out  o_out
);

    t_prod              r_prod [N_COMP][3];
    logic               r_clip;
    logic signed [31:0] n_e [N_COMP];
    logic               n_sat;
    t_sgls_out          r_out;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            for (int p = 0; p < N_COMP; p++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[p][k] <= i_f[k*3+OI[p]] * i_f[k*3+OJ[p]];
                end
            end
            r_clip <= i_clip;
        end
    end

    always_comb begin
        logic signed [35:0] s;
        logic signed [35:0] q;
        logic               zero;
        n_sat = r_clip;
        for (int p = 0; p < N_COMP; p++) begin
            s = 36'(r_prod[p][0]) + 36'(r_prod[p][1]) + 36'(r_prod[p][2]);
            if (OI[p] == OJ[p]) begin
                s = s - 36'sd16777216;
            end
            s    = s + 36'sd256;
            q    = s >>> 9;
            zero = i_ctrl.planar && (OI[p] == 2 || OJ[p] == 2);
            if (zero) begin
                n_e[p] = 32'sd0;
            end else if (q > 36'sd2147483647) begin
                n_e[p] = 32'sh7fffffff;
                n_sat  = 1'b1;
            end else if (q < -36'sd2147483648) begin
                n_e[p] = 32'sh80000000;
                n_sat  = 1'b1;
            end else begin
                n_e[p] = q[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_out.strain_xx <= n_e[0];
            r_out.strain_yy <= n_e[1];
            r_out.strain_zz <= n_e[2];
            r_out.strain_xy <= n_e[3];
            r_out.strain_yz <= n_e[4];
            r_out.strain_xz <= n_e[5];
            r_out.saturated <= n_sat;
        end
    end

    assign o_out = r_out;

endmodule

// ===== design/scaled_green_lagrange_strain_top.sv =====
// ----------------------------------------------------------------------------
// scaled_green_lagrange_strain_top
// Green-Lagrange strain of one scaled displacement gradient per request.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall  t_sgls_in, nine Q4.12 terms
//   out      output     o_out_valid/i_out_stall t_sgls_out, six Q15.16 + flag
//   cfg      input      i_cfg_valid/o_cfg_ready index 3 bits, data 16 bits
//
// One request per cycle unless a waiting result is stalled, which freezes every
// stage; no request is lost or repeated. Five register stages: two multiplier
// stages for the scale factors, the round/saturate stage, the F product stage
// and the sum/round stage. Synchronous active-low reset clears the stage valids,
// selects planar mode and sets each scale factor to SCALE_ONE.
// ----------------------------------------------------------------------------
module scaled_green_lagrange_strain_top import sgls_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_sgls_in    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_sgls_out   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [1:0]       r_mode;
    logic [2:0][15:0] r_dscale;
    logic [2:0][15:0] r_crecip;
    logic [4:0]       r_vld;
    logic [4:0]       n_vld;
    logic             advance;
    t_sgls_cfg        cfg;
    t_sgls_ctrl       ctrl;
    t_fterm           f [N_TERM];
    logic             clip;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLANAR;
            r_dscale <= {3{SCALE_ONE}};
            r_crecip <= {3{SCALE_ONE}};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE:     r_mode      <= i_cfg_data[1:0];
                CFG_DSCALE_X: r_dscale[0] <= i_cfg_data;
                CFG_DSCALE_Y: r_dscale[1] <= i_cfg_data;
                CFG_DSCALE_Z: r_dscale[2] <= i_cfg_data;
                CFG_CRECIP_X: r_crecip[0] <= i_cfg_data;
                CFG_CRECIP_Y: r_crecip[1] <= i_cfg_data;
                CFG_CRECIP_Z: r_crecip[2] <= i_cfg_data;
                default:      r_mode      <= r_mode;
            endcase
        end
    end

    // hold every stage while the result waits
    assign advance    = !(r_vld[4] && i_out_stall);
    assign o_in_stall = !advance;

    assign n_vld = {r_vld[3:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= n_vld;
        end
    end

    assign cfg.planar = (r_mode != MODE_FULL);
    assign cfg.dscale = r_dscale;
    assign cfg.crecip = r_crecip;
    assign ctrl.en     = advance;
    assign ctrl.planar = cfg.planar;

    sgls_scale u_scale (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_cfg  (cfg),
        .i_in   (i_in),
        .o_f    (f),
        .o_clip (clip)
    );

    sgls_strain u_strain (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_f    (f),
        .i_clip (clip),
        .o_out  (o_out)
    );

    assign o_out_valid = r_vld[4];

    a_advance_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_vld[4:1] == $past(r_vld[3:0])))
        else $error("stage valids did not advance");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> (r_vld == $past(r_vld)))
        else $error("stage valids changed during stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted request missing from first stage");

endmodule
